FILE: design/sam_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sam_pkg
// Shared types and constants for the sort-and-median block.
// ----------------------------------------------------------------------------
package sam_pkg;

	localparam int MAX_ELEMENTS_DEF = 64;
	localparam int VALUE_W          = 32;

	// per-cycle command broadcast to every cell of the chain
	typedef struct packed {
		logic insert;   // place the broadcast word into the sorted chain
		logic shift;    // move every word one cell toward the head
	} sam_ctrl_t;

endpackage

FILE: design/sam_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sam_cell
// One slot of the insertion-sort chain: holds one word, compares it against
// the broadcast word and trades data with its neighbors.
// ----------------------------------------------------------------------------
module sam_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sam_pkg::sam_ctrl_t                  ctrl,
	input  logic signed [sam_pkg::VALUE_W-1:0]  new_word,
	input  logic signed [sam_pkg::VALUE_W-1:0]  prev_word,
	input  logic                                prev_valid,
	input  logic                                prev_take,
	input  logic signed [sam_pkg::VALUE_W-1:0]  next_word,
	input  logic                                next_valid,
	output logic signed [sam_pkg::VALUE_W-1:0]  word,
	output logic                                valid,
	output logic                                take
);

	logic signed [sam_pkg::VALUE_W-1:0] word_q;
	logic                               valid_q;

	// equal words stay ahead of the new one
	assign take  = valid_q && (new_word < word_q);
	assign word  = word_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.insert) begin
			valid_q <= valid_q | prev_valid;
		end else if (ctrl.shift) begin
			valid_q <= next_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (prev_take) begin
				word_q <= prev_word;
			end else if (take || (!valid_q && prev_valid)) begin
				word_q <= new_word;
			end
		end else if (ctrl.shift) begin
			word_q <= next_word;
		end
	end

endmodule

FILE: design/sort_and_median.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sort_and_median
// Streams a set of signed words into an insertion-sort cell chain, then emits
// the set ascending with the median (element count/2) on every result.
// ----------------------------------------------------------------------------
// Loading: one word per cycle, busy stays low; the cell chain sorts on entry.
// After the word marked is_final: the S_PICK state registers the median, then the n
// results follow in S_EMIT, one per cycle.
// busy is high through S_PICK and S_EMIT; the next set may start the cycle after.
// The receiver cannot stall: strobe marks each result for one cycle.
// Reset clears the element count, overflow flag and every cell's valid bit.
module sort_and_median #(
	parameter int MAX_ELEMENTS = sam_pkg::MAX_ELEMENTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [sam_pkg::VALUE_W-1:0]  value,
	input  logic                                is_final,
	output logic                                strobe,
	output logic signed [sam_pkg::VALUE_W-1:0]  sorted_value,
	output logic signed [sam_pkg::VALUE_W-1:0]  median_value,
	output logic                                end_of_run,
	output logic                                dropped
);

	localparam int CW = $clog2(MAX_ELEMENTS + 1);

	typedef enum logic [1:0] {S_LOAD, S_PICK, S_EMIT} state_t;

	state_t                              state_q;
	logic [CW-1:0]                       count_q;
	logic                                overflow_q;
	logic signed [sam_pkg::VALUE_W-1:0]  median_q;
	logic signed [sam_pkg::VALUE_W-1:0]  median_mux;

	logic signed [sam_pkg::VALUE_W-1:0]  cell_word  [MAX_ELEMENTS];
	logic                                cell_valid [MAX_ELEMENTS];
	logic                                cell_take  [MAX_ELEMENTS];

	sam_pkg::sam_ctrl_t ctrl;
	logic               accept;
	logic               full;

	assign accept      = start && (state_q == S_LOAD);
	assign full        = (count_q >= CW'(MAX_ELEMENTS));
	assign ctrl.insert = accept && !full;
	assign ctrl.shift  = (state_q == S_EMIT);

	for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
		logic signed [sam_pkg::VALUE_W-1:0] prev_word, next_word;
		logic                               prev_valid, prev_take, next_valid;

		if (i == 0) begin : g_head
			assign prev_word  = '0;
			assign prev_valid = 1'b1;
			assign prev_take  = 1'b0;
		end else begin : g_body
			assign prev_word  = cell_word[i-1];
			assign prev_valid = cell_valid[i-1];
			assign prev_take  = cell_take[i-1];
		end

		if (i == MAX_ELEMENTS - 1) begin : g_tail
			assign next_word  = '0;
			assign next_valid = 1'b0;
		end else begin : g_inner
			assign next_word  = cell_word[i+1];
			assign next_valid = cell_valid[i+1];
		end

		sam_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.new_word   (value),
			.prev_word  (prev_word),
			.prev_valid (prev_valid),
			.prev_take  (prev_take),
			.next_word  (next_word),
			.next_valid (next_valid),
			.word       (cell_word[i]),
			.valid      (cell_valid[i]),
			.take       (cell_take[i])
		);
	end

	// one-hot pick of the cell at count/2
	always_comb begin
		median_mux = '0;
		for (int i = 0; i < MAX_ELEMENTS; i++) begin
			if (CW'(i) == (count_q >> 1)) begin
				median_mux = median_mux | cell_word[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (full) begin
							overflow_q <= 1'b1;
						end else begin
							count_q <= count_q + CW'(1);
						end
						if (is_final) begin
							state_q <= S_PICK;
						end
					end
				end
				S_PICK: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					count_q <= count_q - CW'(1);
					if (count_q == CW'(1)) begin
						state_q    <= S_LOAD;
						overflow_q <= 1'b0;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_PICK) begin
			median_q <= median_mux;
		end
	end

	assign busy         = (state_q != S_LOAD);
	assign strobe       = (state_q == S_EMIT);
	assign sorted_value = cell_word[0];
	assign median_value = median_q;
	assign end_of_run   = strobe && (count_q == CW'(1));
	assign dropped      = overflow_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ELEMENTS))
		else $error("element count past capacity");

	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> cell_valid[0])
		else $error("word emitted from empty head cell");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		end_of_run |=> !strobe && !busy)
		else $error("results continue after end of run");

	a_final_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_final) |=> busy && !strobe)
		else $error("final word did not start the pick cycle");

	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PICK) |-> (count_q != '0))
		else $error("empty set entered emit");

endmodule
